>>> design/ihex_enc_pkg.sv
// Shared types, constants and the sequencer microcode for the Intel HEX record encoder.
// Used by the encoder core and its port checker; no dependencies.
`timescale 1ns / 1ps

package ihex_enc_pkg;

   // configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int LEN_W      = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LENGTH = 1'b1;
   localparam logic [LEN_W-1:0]     LEN_RESET         = 6'd16;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_input;
   } ihex_req_type;

   typedef struct packed {
      logic [6:0] high_digit;
      logic [6:0] low_digit;
      logic       record_start;
      logic       record_end;
      logic       final_of_run;
   } ihex_rsp_type;

   // byte sources of the datapath
   localparam int SRC_W = 3;
   localparam logic [SRC_W-1:0] SRC_ZERO  = 3'd0;
   localparam logic [SRC_W-1:0] SRC_ONE   = 3'd1;
   localparam logic [SRC_W-1:0] SRC_COUNT = 3'd2;
   localparam logic [SRC_W-1:0] SRC_AHI   = 3'd3;
   localparam logic [SRC_W-1:0] SRC_ALO   = 3'd4;
   localparam logic [SRC_W-1:0] SRC_DATA  = 3'd5;
   localparam logic [SRC_W-1:0] SRC_CHECK = 3'd6;

   // step sequencing conditions
   localparam int COND_W = 2;
   localparam logic [COND_W-1:0] COND_DISPATCH = 2'd0;
   localparam logic [COND_W-1:0] COND_NEXT     = 2'd1;
   localparam logic [COND_W-1:0] COND_LOOP     = 2'd2;
   localparam logic [COND_W-1:0] COND_EOF      = 2'd3;

   // program steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_COUNT     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_AHI       = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ALO       = 4'd3;
   localparam logic [STEP_W-1:0] STEP_TYPE      = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DATA      = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CHECK     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_EOF_COUNT = 4'd7;
   localparam logic [STEP_W-1:0] STEP_EOF_AHI   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_EOF_ALO   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EOF_TYPE  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_EOF_CHECK = 4'd11;

   typedef struct packed {
      logic              emit;
      logic [SRC_W-1:0]  src;
      logic              first;
      logic              last;
      logic              eof_rec;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } ihex_cw_type;

   function automatic ihex_cw_type ihex_ucode(input logic [STEP_W-1:0] step);
      ihex_cw_type cw;
      cw = '{emit: 1'b0, src: SRC_ZERO, first: 1'b0, last: 1'b0, eof_rec: 1'b0,
             cond: COND_DISPATCH, target: STEP_COUNT};
      unique case (step)
         STEP_IDLE: ;
         STEP_COUNT: cw = '{1'b1, SRC_COUNT, 1'b1, 1'b0, 1'b0, COND_NEXT, STEP_AHI};
         STEP_AHI:   cw = '{1'b1, SRC_AHI,   1'b0, 1'b0, 1'b0, COND_NEXT, STEP_ALO};
         STEP_ALO:   cw = '{1'b1, SRC_ALO,   1'b0, 1'b0, 1'b0, COND_NEXT, STEP_TYPE};
         STEP_TYPE:  cw = '{1'b1, SRC_ZERO,  1'b0, 1'b0, 1'b0, COND_NEXT, STEP_DATA};
         STEP_DATA:  cw = '{1'b1, SRC_DATA,  1'b0, 1'b0, 1'b0, COND_LOOP, STEP_CHECK};
         STEP_CHECK: cw = '{1'b1, SRC_CHECK, 1'b0, 1'b1, 1'b0, COND_EOF,  STEP_IDLE};
         STEP_EOF_COUNT:
            cw = '{1'b1, SRC_ZERO,  1'b1, 1'b0, 1'b1, COND_NEXT, STEP_EOF_AHI};
         STEP_EOF_AHI:
            cw = '{1'b1, SRC_ZERO,  1'b0, 1'b0, 1'b1, COND_NEXT, STEP_EOF_ALO};
         STEP_EOF_ALO:
            cw = '{1'b1, SRC_ZERO,  1'b0, 1'b0, 1'b1, COND_NEXT, STEP_EOF_TYPE};
         STEP_EOF_TYPE:
            cw = '{1'b1, SRC_ONE,   1'b0, 1'b0, 1'b1, COND_NEXT, STEP_EOF_CHECK};
         STEP_EOF_CHECK:
            cw = '{1'b1, SRC_CHECK, 1'b0, 1'b1, 1'b1, COND_NEXT, STEP_IDLE};
         default: cw = '{1'b0, SRC_ZERO, 1'b0, 1'b0, 1'b0, COND_NEXT, STEP_IDLE};
      endcase
      return cw;
   endfunction

   function automatic logic [6:0] ihex_digit(input logic [3:0] nibble);
      return (nibble < 4'd10) ? (7'd48 + 7'(nibble)) : (7'd55 + 7'(nibble));
   endfunction

endpackage

>>> design/intel_hex_record_encoder_core.sv
// Intel HEX data record encoder, top level: microcoded sequencer and byte datapath.
// Depends on ihex_enc_pkg and ihex_enc_buffer.
//
//   channel | ports                          | moves
//   --------+--------------------------------+---------------------------------------
//   req     | req_valid req_ready req_data   | one raw byte and/or end marker per item
//   rsp     | rsp_valid rsp_ready rsp_data   | one ASCII hex pair per item
//   csr     | csr_we csr_index csr_wdata     | start_address, record_length writes
//
// An item that causes no record leaves the step counter on the idle step. An item that
// closes a data record of N bytes is sent as one output pair per microcode step; end of
// input adds the 5 steps of the EOF record. The step counter walks one control word per
// cycle off the idle step unless rsp stalls. req_ready is high only on the idle step.
// A stalled rsp holds the step counter. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps

module intel_hex_record_encoder_core
   import ihex_enc_pkg::*;
#(
   parameter int MAX_RECORD_BYTES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ihex_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ihex_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 1);
   localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
   localparam int CMP_W = LEN_W + 1;

   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ihex_rsp_type          rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [7:0]            sum_ff, sum_in;
   logic                  eof_ff, eof_in;
   logic [15:0]           start_ff, start_in;
   logic [15:0]           next_ff, next_in;
   logic [15:0]           rec_addr_ff, rec_addr_in;
   logic [LEN_W-1:0]      len_ff, len_in;

   ihex_cw_type           cw;
   logic                  accept;
   logic                  fire;
   logic                  last_byte;
   logic                  do_data;
   logic [CNT_W-1:0]      fill_new;
   logic [LEN_W-1:0]      eff_len;
   logic [7:0]            out_byte;
   logic [7:0]            rd_byte;

   assign req_ready = (step_ff == STEP_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ihex_enc_buffer #(
      .DEPTH (MAX_RECORD_BYTES),
      .IDX_W (IDX_W)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (accept && req_data.has_byte),
      .wr_idx  (fill_ff[IDX_W-1:0]),
      .wr_byte (req_data.data_byte),
      .rd_idx  (idx_in),
      .rd_byte (rd_byte)
   );

   always_comb begin
      cw        = ihex_ucode(step_ff);
      fire      = cw.emit && (!rsp_valid_ff || rsp_ready);
      last_byte = (CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff;

      // zero reads as one, too large saturates
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_RECORD_BYTES)) begin
         eff_len = LEN_W'(MAX_RECORD_BYTES);
      end else begin
         eff_len = len_ff;
      end

      fill_new = fill_ff + CNT_W'(req_data.has_byte);
      do_data  = (req_data.has_byte && (CMP_W'(fill_new) >= CMP_W'(eff_len)))
                 || (req_data.end_of_input && (fill_new != '0));

      unique case (cw.src)
         SRC_ZERO:  out_byte = 8'h00;
         SRC_ONE:   out_byte = 8'h01;
         SRC_COUNT: out_byte = 8'(cnt_ff);
         SRC_AHI:   out_byte = rec_addr_ff[15:8];
         SRC_ALO:   out_byte = rec_addr_ff[7:0];
         SRC_DATA:  out_byte = rd_byte;
         SRC_CHECK: out_byte = 8'h00 - sum_ff;
         default:   out_byte = 8'h00;
      endcase

      step_in = step_ff;
      unique case (cw.cond)
         COND_DISPATCH: begin
            if (accept) begin
               if (do_data) begin
                  step_in = cw.target;
               end else if (req_data.end_of_input) begin
                  step_in = STEP_EOF_COUNT;
               end
            end
         end
         COND_NEXT: begin
            if (fire) step_in = cw.target;
         end
         COND_LOOP: begin
            if (fire && last_byte) step_in = cw.target;
         end
         COND_EOF: begin
            if (fire) step_in = eof_ff ? STEP_EOF_COUNT : cw.target;
         end
      endcase

      // output register: load on a step that emits, drop when taken
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.high_digit   = ihex_digit(out_byte[7:4]);
         rsp_data_in.low_digit    = ihex_digit(out_byte[3:0]);
         rsp_data_in.record_start = cw.first;
         rsp_data_in.record_end   = cw.last;
         rsp_data_in.final_of_run = cw.last && (cw.eof_rec || !eof_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      sum_in = sum_ff;
      if (fire) begin
         sum_in = cw.first ? out_byte : (sum_ff + out_byte);
      end

      idx_in = idx_ff;
      if (accept) begin
         idx_in = '0;
      end else if (fire && (cw.src == SRC_DATA) && !last_byte) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      fill_in     = fill_ff;
      cnt_in      = cnt_ff;
      eof_in      = eof_ff;
      rec_addr_in = rec_addr_ff;
      next_in     = next_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      if (accept) begin
         fill_in = do_data ? '0 : fill_new;
         cnt_in  = fill_new;
         eof_in  = req_data.end_of_input;
         if (req_data.has_byte) begin
            if (fill_ff == '0) rec_addr_in = next_ff;
            next_in = next_ff + 16'd1;
         end
         // restart addressing for the next image
         if (req_data.end_of_input) next_in = start_ff;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_START_ADDRESS: begin
               start_in = csr_wdata;
               next_in  = csr_wdata;
            end
            CSR_RECORD_LENGTH: len_in = csr_wdata[LEN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         eof_ff       <= 1'b0;
         start_ff     <= 16'h0000;
         next_ff      <= 16'h0000;
         rec_addr_ff  <= 16'h0000;
         len_ff       <= LEN_RESET;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         eof_ff       <= eof_in;
         start_ff     <= start_in;
         next_ff      <= next_in;
         rec_addr_ff  <= rec_addr_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
   end

endmodule

>>> design/ihex_enc_buffer.sv
// Record buffer of the Intel HEX encoder: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module ihex_enc_buffer #(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [7:0]       wr_byte,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [7:0]       rd_byte
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_byte_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_byte;
      end
      rd_byte_ff <= mem[rd_idx];
   end

   assign rd_byte = rd_byte_ff;

endmodule

>>> design/ihex_enc_checker.sv
// Port-level checker for the Intel HEX encoder core, bound to the top level.
// Depends on ihex_enc_pkg and intel_hex_record_encoder_core.
`timescale 1ns / 1ps

module ihex_enc_checker
   import ihex_enc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input ihex_rsp_type rsp_data
);

   // hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed or dropped while stalled");

   a_hex_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_data.high_digit >= 7'd48 && rsp_data.high_digit <= 7'd57) ||
          (rsp_data.high_digit >= 7'd65 && rsp_data.high_digit <= 7'd70)) &&
         ((rsp_data.low_digit >= 7'd48 && rsp_data.low_digit <= 7'd57) ||
          (rsp_data.low_digit >= 7'd65 && rsp_data.low_digit <= 7'd70)))
      else $error("rsp digit is not an upper-case hex character");

   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_of_run |-> rsp_data.record_end)
      else $error("run ended inside a record");

   a_start_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.record_start && rsp_data.record_end))
      else $error("pair both opens and closes a record");

endmodule

bind intel_hex_record_encoder_core ihex_enc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
